[rtl/core/bdy_pkg.sv]
// Buddy allocator package: command, status and mark codes, fixed widths.
// Used by bdy_cfg, bdy_seq, buddy_allocator_top and bdy_chk. No dependencies.
`default_nettype none
package bdy_pkg;

  localparam int GRAN_LOG = 5;
  localparam int CNT_W    = 12;
  localparam int CMD_W    = 2;
  localparam int ST_W     = 3;
  localparam int MSZ_W    = 17;
  localparam int BYTE_W   = 16;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REINIT = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO    = 3'd1;
  localparam logic [ST_W-1:0] ST_NOMEM   = 3'd2;
  localparam logic [ST_W-1:0] ST_NULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_BADFREE = 3'd4;

  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_FREE = 2'd1;
  localparam logic [1:0] MARK_USED = 2'd2;

  // smallest order whose size exceeds the header, at least one granule
  function automatic int min_order(input int header);
    int m;
    m = 0;
    while ((1 << m) <= header) m++;
    return (m < GRAN_LOG) ? GRAN_LOG : m;
  endfunction

endpackage
`default_nettype wire

[rtl/core/bdy_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module bdy_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/bdy_cfg.sv]
// APB-style register port holding the managed region size.
// Depends on bdy_pkg.
`default_nettype none
module bdy_cfg
  import bdy_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [MSZ_W-1:0] region_size
);

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(region_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      region_size <= MSZ_W'(65536);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      region_size <= pwdata[MSZ_W-1:0];
    end
  end

endmodule
`default_nettype wire

[rtl/core/bdy_seq.sv]
// Allocator sequencer: free-list heads and counts, link and granule memories,
// and the state machine for allocate, free/merge and reinitialize.
// Depends on bdy_pkg and bdy_ram.
`default_nettype none
module bdy_seq
  import bdy_pkg::*;
#(
  parameter int MEM_LOG2     = 16,
  parameter int HEADER_BYTES = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [CMD_W-1:0]  command,
  input  logic [BYTE_W-1:0] request_bytes,
  input  logic [BYTE_W-1:0] free_address,
  input  logic [MSZ_W-1:0]  region_size,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [ST_W-1:0]   status,
  output logic [BYTE_W-1:0] block_address,
  output logic [CNT_W-1:0]  used_blocks,
  output logic [CNT_W-1:0]  free_blocks
);

  localparam int GW      = MEM_LOG2 - GRAN_LOG;
  localparam int NGRAN   = 1 << GW;
  localparam int LW      = GW + 1;
  localparam int NORD    = MEM_LOG2 + 1;
  localparam int OW      = $clog2(NORD);
  localparam int SZ_W    = MEM_LOG2 + 1;
  localparam int N_W     = BYTE_W + 1;
  localparam int MIN_ORD = min_order(HEADER_BYTES);
  localparam logic [LW-1:0] NIL = {1'b1, {GW{1'b0}}};

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_DONE    = 5'd2;
  localparam logic [4:0] S_RI_INIT = 5'd3;
  localparam logic [4:0] S_RI_LOOP = 5'd4;
  localparam logic [4:0] S_RI_NEXT = 5'd5;
  localparam logic [4:0] S_AL_SRCH = 5'd6;
  localparam logic [4:0] S_AL_SPLT = 5'd7;
  localparam logic [4:0] S_AL_P1   = 5'd8;
  localparam logic [4:0] S_AL_P2   = 5'd9;
  localparam logic [4:0] S_AL_FIN  = 5'd10;
  localparam logic [4:0] S_FR_CHK  = 5'd11;
  localparam logic [4:0] S_MG_TEST = 5'd12;
  localparam logic [4:0] S_MG_WALK = 5'd13;
  localparam logic [4:0] S_MG_CMP  = 5'd14;
  localparam logic [4:0] S_MG_U2   = 5'd15;
  localparam logic [4:0] S_MG_PUSH = 5'd16;
  localparam logic [4:0] S_PUSH    = 5'd17;
  localparam logic [4:0] S_POP0    = 5'd18;
  localparam logic [4:0] S_POP1    = 5'd19;
  localparam logic [4:0] S_UL0     = 5'd20;
  localparam logic [4:0] S_UL1     = 5'd21;
  localparam logic [4:0] S_UL2     = 5'd22;
  localparam logic [4:0] S_RMW0    = 5'd23;
  localparam logic [4:0] S_RMW1    = 5'd24;

  typedef struct packed {
    logic [LW-1:0] nxt;
    logic [LW-1:0] prv;
  } link_t;

  typedef struct packed {
    logic [OW-1:0] ord;
    logic [1:0]    mark;
  } meta_t;

  logic [4:0]       state, ret, rmw_ret;
  logic [GW-1:0]    cg, hh, ua, ub, rmw_addr, clr_cnt;
  logic [OW-1:0]    ck, alloc_k, top;
  logic [LW-1:0]    tt, rmw_val, ul_pv, ul_nx;
  logic             rmw_sel, ri_pend;
  logic [SZ_W-1:0]  sz, base;
  logic [CNT_W-1:0] used_tot, free_tot;
  logic [ST_W-1:0]  res_status;
  logic [BYTE_W-1:0] res_addr;
  logic [LW-1:0]    heads [NORD];
  logic [CNT_W-1:0] cnts [NORD];

  logic          l_we, m_we;
  logic [GW-1:0] l_waddr, l_raddr, m_waddr, m_raddr;
  link_t         l_wdata, l_rdata;
  meta_t         m_wdata, m_rdata;

  // request decode
  logic [N_W-1:0]    n_need, n_m1;
  logic [5:0]        k_raw, ka;
  logic [BYTE_W-1:0] off;
  logic              fa_bad;
  logic [GW-1:0]     fg;
  logic [SZ_W-1:0]   sz_sat;
  logic [OW-1:0]     tp;
  logic [GW-1:0]     ma, mb, half;
  logic [LW-1:0]     gsz;
  logic              mg_hit;

  always_comb begin
    n_need = N_W'(request_bytes) + N_W'(HEADER_BYTES);
    n_m1   = n_need - N_W'(1);
    k_raw  = 6'd0;
    for (int i = 0; i < N_W; i++) begin
      if (n_m1[i]) k_raw = 6'(i + 1);
    end
    ka = (k_raw < 6'(MIN_ORD)) ? 6'(MIN_ORD) : k_raw;

    off    = free_address - BYTE_W'(HEADER_BYTES);
    fa_bad = (free_address < BYTE_W'(HEADER_BYTES)) ||
             (off[GRAN_LOG-1:0] != '0) ||
             ((32'(off) >> GRAN_LOG) >= 32'(NGRAN));
    fg     = GW'(off >> GRAN_LOG);

    sz_sat = (32'(region_size) > (32'(1) << MEM_LOG2)) ? SZ_W'(32'(1) << MEM_LOG2)
                                                       : SZ_W'(region_size);
    tp = '0;
    for (int i = 0; i < SZ_W; i++) begin
      if (sz[i]) tp = OW'(i);
    end

    ma     = (tt[GW-1:0] < hh) ? tt[GW-1:0] : hh;
    mb     = (tt[GW-1:0] < hh) ? hh : tt[GW-1:0];
    gsz    = LW'(1) << (ck - OW'(GRAN_LOG));
    mg_hit = (({1'b0, ma} & ((gsz << 1) - LW'(1))) == '0) &&
             (({1'b0, ma} + gsz) == {1'b0, mb});
    half   = GW'(1) << (ck - OW'(GRAN_LOG));
  end

  assign req_stall = (state != S_IDLE);

  // memory ports
  always_comb begin
    l_we    = 1'b0;
    l_waddr = cg;
    l_wdata = '0;
    l_raddr = cg;
    m_we    = 1'b0;
    m_waddr = cg;
    m_wdata = '0;
    m_raddr = cg;
    case (state)
      S_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_cnt;
      end
      S_IDLE: m_raddr = fg;
      S_PUSH: begin
        l_we    = 1'b1;
        l_wdata = {heads[ck], NIL};
        m_we    = 1'b1;
        m_wdata = {ck, MARK_FREE};
      end
      S_POP0:    l_raddr = heads[ck][GW-1:0];
      S_MG_TEST: l_raddr = heads[ck][GW-1:0];
      S_MG_CMP:  l_raddr = tt[GW-1:0];
      S_RMW0:    l_raddr = rmw_addr;
      S_RMW1: begin
        l_we    = 1'b1;
        l_waddr = rmw_addr;
        l_wdata = rmw_sel ? {rmw_val, l_rdata.prv} : {l_rdata.nxt, rmw_val};
      end
      S_AL_FIN: begin
        m_we    = 1'b1;
        m_wdata = {ck, MARK_USED};
      end
      S_MG_PUSH: begin
        m_we    = 1'b1;
        m_waddr = ub;
        m_wdata = {ck, MARK_NONE};
      end
      default: ;
    endcase
  end

  bdy_ram #(.WIDTH(2 * LW), .DEPTH(NGRAN)) u_link (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  bdy_ram #(.WIDTH(OW + 2), .DEPTH(NGRAN)) u_meta (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      ri_pend   <= 1'b0;
      rsp_valid <= 1'b0;
      top       <= '0;
      used_tot  <= '0;
      free_tot  <= '0;
      for (int i = 0; i < NORD; i++) begin
        heads[i] <= NIL;
        cnts[i]  <= '0;
      end
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) rsp_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + GW'(1);
          if (&clr_cnt) begin
            state   <= ri_pend ? S_RI_INIT : S_IDLE;
            ri_pend <= 1'b0;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            res_addr <= '0;
            case (command)
              CMD_ALLOC: begin
                if (request_bytes == '0) begin
                  res_status <= ST_ZERO;
                  state      <= S_DONE;
                end else if (ka > 6'(top)) begin
                  res_status <= ST_NOMEM;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  alloc_k    <= OW'(ka);
                  ck         <= OW'(ka);
                  state      <= S_AL_SRCH;
                end
              end
              CMD_FREE: begin
                if (free_address == '0) begin
                  res_status <= ST_NULL;
                  state      <= S_DONE;
                end else if (fa_bad) begin
                  res_status <= ST_BADFREE;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  cg         <= fg;
                  state      <= S_FR_CHK;
                end
              end
              CMD_REINIT: begin
                for (int i = 0; i < NORD; i++) begin
                  heads[i] <= NIL;
                  cnts[i]  <= '0;
                end
                res_status <= ST_OK;
                used_tot   <= '0;
                free_tot   <= '0;
                top        <= '0;
                sz         <= sz_sat;
                clr_cnt    <= '0;
                ri_pend    <= 1'b1;
                state      <= S_CLR;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid     <= 1'b1;
            status        <= res_status;
            block_address <= res_addr;
            used_blocks   <= used_tot;
            free_blocks   <= free_tot;
            state         <= S_IDLE;
          end
        end
        S_RI_INIT: begin
          top   <= tp;
          ck    <= tp;
          base  <= '0;
          state <= S_RI_LOOP;
        end
        S_RI_LOOP: begin
          if (ck < OW'(MIN_ORD)) begin
            state <= S_DONE;
          end else if (sz[ck]) begin
            cg    <= GW'(base >> GRAN_LOG);
            base  <= base + (SZ_W'(1) << ck);
            ret   <= S_RI_NEXT;
            state <= S_PUSH;
          end else begin
            state <= S_RI_NEXT;
          end
        end
        S_RI_NEXT: begin
          ck    <= ck - OW'(1);
          state <= S_RI_LOOP;
        end
        S_AL_SRCH: begin
          if (cnts[ck] != '0) begin
            state <= S_AL_SPLT;
          end else if (ck == top) begin
            res_status <= ST_NOMEM;
            state      <= S_DONE;
          end else begin
            ck <= ck + OW'(1);
          end
        end
        S_AL_SPLT: begin
          ret   <= (ck == alloc_k) ? S_AL_FIN : S_AL_P1;
          state <= S_POP0;
        end
        S_AL_P1: begin
          ck    <= ck - OW'(1);
          ret   <= S_AL_P2;
          state <= S_PUSH;
        end
        S_AL_P2: begin
          cg    <= cg + half;
          ret   <= S_AL_SPLT;
          state <= S_PUSH;
        end
        S_AL_FIN: begin
          used_tot <= used_tot + CNT_W'(1);
          res_addr <= BYTE_W'((32'(cg) << GRAN_LOG) + 32'(HEADER_BYTES));
          state    <= S_DONE;
        end
        S_FR_CHK: begin
          if (m_rdata.mark != MARK_USED) begin
            res_status <= ST_BADFREE;
            state      <= S_DONE;
          end else begin
            ck       <= m_rdata.ord;
            used_tot <= used_tot - CNT_W'(1);
            ret      <= S_MG_TEST;
            state    <= S_PUSH;
          end
        end
        S_MG_TEST: begin
          if (ck < OW'(MEM_LOG2) && cnts[ck] >= CNT_W'(2)) begin
            hh    <= heads[ck][GW-1:0];
            state <= S_MG_WALK;
          end else begin
            state <= S_DONE;
          end
        end
        S_MG_WALK: begin
          tt    <= l_rdata.nxt;
          state <= S_MG_CMP;
        end
        S_MG_CMP: begin
          if (tt[GW]) begin
            state <= S_DONE;
          end else if (mg_hit) begin
            ua    <= ma;
            ub    <= mb;
            cg    <= ma;
            ret   <= S_MG_U2;
            state <= S_UL0;
          end else begin
            state <= S_MG_WALK;
          end
        end
        S_MG_U2: begin
          cg    <= ub;
          ret   <= S_MG_PUSH;
          state <= S_UL0;
        end
        S_MG_PUSH: begin
          cg    <= ua;
          ck    <= ck + OW'(1);
          ret   <= S_MG_TEST;
          state <= S_PUSH;
        end
        S_PUSH: begin
          heads[ck] <= {1'b0, cg};
          cnts[ck]  <= cnts[ck] + CNT_W'(1);
          free_tot  <= free_tot + CNT_W'(1);
          if (!heads[ck][GW]) begin
            rmw_addr <= heads[ck][GW-1:0];
            rmw_val  <= {1'b0, cg};
            rmw_sel  <= 1'b0;
            rmw_ret  <= ret;
            state    <= S_RMW0;
          end else begin
            state <= ret;
          end
        end
        S_POP0: begin
          cg    <= heads[ck][GW-1:0];
          state <= S_POP1;
        end
        S_POP1: begin
          heads[ck] <= l_rdata.nxt;
          cnts[ck]  <= cnts[ck] - CNT_W'(1);
          free_tot  <= free_tot - CNT_W'(1);
          if (!l_rdata.nxt[GW]) begin
            rmw_addr <= l_rdata.nxt[GW-1:0];
            rmw_val  <= NIL;
            rmw_sel  <= 1'b0;
            rmw_ret  <= ret;
            state    <= S_RMW0;
          end else begin
            state <= ret;
          end
        end
        S_UL0: state <= S_UL1;
        S_UL1: begin
          ul_pv    <= l_rdata.prv;
          ul_nx    <= l_rdata.nxt;
          cnts[ck] <= cnts[ck] - CNT_W'(1);
          free_tot <= free_tot - CNT_W'(1);
          if (!l_rdata.prv[GW]) begin
            rmw_addr <= l_rdata.prv[GW-1:0];
            rmw_val  <= l_rdata.nxt;
            rmw_sel  <= 1'b1;
            rmw_ret  <= S_UL2;
            state    <= S_RMW0;
          end else begin
            heads[ck] <= l_rdata.nxt;
            state     <= S_UL2;
          end
        end
        S_UL2: begin
          if (!ul_nx[GW]) begin
            rmw_addr <= ul_nx[GW-1:0];
            rmw_val  <= ul_pv;
            rmw_sel  <= 1'b0;
            rmw_ret  <= ret;
            state    <= S_RMW0;
          end else begin
            state <= ret;
          end
        end
        S_RMW0: state <= S_RMW1;
        S_RMW1: state <= rmw_ret;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/buddy_allocator_top.sv]
// Buddy allocator top level: register port and allocation sequencer.
// Depends on bdy_pkg, bdy_cfg, bdy_seq (and bdy_ram below it).
//
//   channel   direction  handshake             payload
//   request   in         req_valid/req_stall   command, request_bytes, free_address
//   response  out        rsp_valid/rsp_stall   status, block_address, used_blocks,
//                                              free_blocks
//   config    in         APB psel/penable      paddr, pwdata, prdata
//
// One request at a time; list pushes and pops use the registered RAM read port.
// Allocate searches upward by order for a free block and splits it down; free
// walks the list at the block's order and merges buddies upward.
// Reset and each reinitialize clear the granule marks, one entry a cycle,
// with req_stall high throughout.
// A response waiting on rsp_stall holds; the next request is still taken.
`default_nettype none
module buddy_allocator_top
  import bdy_pkg::*;
#(
  parameter int MEM_LOG2     = 16,
  parameter int HEADER_BYTES = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [CMD_W-1:0]  command,
  input  logic [BYTE_W-1:0] request_bytes,
  input  logic [BYTE_W-1:0] free_address,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [ST_W-1:0]   status,
  output logic [BYTE_W-1:0] block_address,
  output logic [CNT_W-1:0]  used_blocks,
  output logic [CNT_W-1:0]  free_blocks
);

  logic [MSZ_W-1:0] region_size;

  bdy_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .region_size (region_size)
  );

  bdy_seq #(.MEM_LOG2(MEM_LOG2), .HEADER_BYTES(HEADER_BYTES)) u_seq (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .command       (command),
    .request_bytes (request_bytes),
    .free_address  (free_address),
    .region_size   (region_size),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .block_address (block_address),
    .used_blocks   (used_blocks),
    .free_blocks   (free_blocks)
  );

endmodule
`default_nettype wire

[rtl/core/bdy_chk.sv]
// Port-level checker for buddy_allocator_top, attached with bind.
// Depends on bdy_pkg.
`default_nettype none
module bdy_chk
  import bdy_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input logic [ST_W-1:0]   status,
  input logic [BYTE_W-1:0] block_address
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status))
    else $error("response dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous one in flight");

  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> block_address == '0)
    else $error("nonzero address on failed request");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= ST_BADFREE)
    else $error("status code out of range");

endmodule

bind buddy_allocator_top bdy_chk u_chk (.*);
`default_nettype wire
